// ----- sv/fcpu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Fly camera pose update: shared package
// Holds the command codes, the controller-to-datapath command and status
// structs, the fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package fcpu_pkg;

    // Default number of CORDIC rotations.
    localparam int TRIG_ITER_DEFAULT = 16;

    // Width of the shared step counter.
    localparam int CNT_W = 5;

    // Step counts of the iterative units.
    localparam int WRAP_STEPS = 11;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;

    // Angle constants in millidegrees.
    localparam int YAW_FULL      = 360000;
    localparam int YAW_HALF      = 180000;
    localparam int ANGLE_QUARTER = 90000;
    localparam int PITCH_LIMIT   = 89000;
    localparam int NDEG_PER_MDEG = 1000000;
    localparam int WRAP_BIAS     = YAW_FULL * 1024;

    // Fixed-point constants.
    localparam int CORDIC_ONE   = 1 << 28;
    localparam int FOV_CEIL     = 32767;
    localparam int NORM_CEIL    = 32767;
    localparam int ROUND_Q14    = 8192;

    // Reset values.
    localparam logic signed [31:0] POS_Z_RESET = 32'sd262144;
    localparam logic signed [15:0] DIR_Z_RESET = -16'sd16384;
    localparam logic [15:0] MIN_VIEW_RESET = 16'd256;
    localparam logic [15:0] MAX_VIEW_RESET = 16'd11520;
    localparam logic [11:0] SENS_RESET     = 12'd100;
    localparam logic [18:0] YAW_RESET      = 19'd270000;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_VIEW = 2'd0;
    localparam logic [1:0] REG_MAX_VIEW = 2'd1;
    localparam logic [1:0] REG_SENS     = 2'd2;

    // Command codes of an input request.
    typedef enum logic [3:0] {
        CMD_FWD       = 4'd0,
        CMD_BACK      = 4'd1,
        CMD_LEFT      = 4'd2,
        CMD_RIGHT     = 4'd3,
        CMD_UP        = 4'd4,
        CMD_DOWN      = 4'd5,
        CMD_FOV_CHG   = 4'd6,
        CMD_FOV_SET   = 4'd7,
        CMD_CURSOR    = 4'd8,
        CMD_READ      = 4'd9,
        CMD_FRONT_SET = 4'd10
    } cmd_code_t;

    // Operand selection of the three multiplier lanes.
    typedef enum logic [2:0] {
        MUL_DIR   = 3'd0,
        MUL_NORM  = 3'd1,
        MUL_CUR   = 3'd2,
        MUL_SQ    = 3'd3,
        MUL_FRONT = 3'd4
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     pos_upd;
        logic     simple_upd;
        logic     cur_upd;
        logic     cur_add;
        logic     wrap_step;
        logic     cord_load;
        logic     cord_sel;
        logic     cord_step;
        logic     vload;
        logic     vsrc_front;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     norm_store;
        logic     dir_from_norm;
        logic     out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] op;
        logic       wrap_last;
        logic       cord_last;
        logic       sqrt_last;
        logic       div_last;
    } dp_sts_t;

    // Arctangent of 2^-i in nanodegrees.
    function automatic logic signed [39:0] atan_ndeg(input logic [4:0] idx);
        logic signed [39:0] r;
        case (idx)
            5'd0:    r = 40'sd45000000000;
            5'd1:    r = 40'sd26565051177;
            5'd2:    r = 40'sd14036243468;
            5'd3:    r = 40'sd7125016349;
            5'd4:    r = 40'sd3576334375;
            5'd5:    r = 40'sd1789910608;
            5'd6:    r = 40'sd895173710;
            5'd7:    r = 40'sd447614171;
            5'd8:    r = 40'sd223810500;
            5'd9:    r = 40'sd111905677;
            5'd10:   r = 40'sd55952892;
            5'd11:   r = 40'sd27976453;
            5'd12:   r = 40'sd13988227;
            5'd13:   r = 40'sd6994114;
            5'd14:   r = 40'sd3497057;
            5'd15:   r = 40'sd1748528;
            5'd16:   r = 40'sd874264;
            5'd17:   r = 40'sd437132;
            5'd18:   r = 40'sd218566;
            5'd19:   r = 40'sd109283;
            5'd20:   r = 40'sd54642;
            5'd21:   r = 40'sd27321;
            5'd22:   r = 40'sd13660;
            5'd23:   r = 40'sd6830;
            default: r = '0;
        endcase
        return r;
    endfunction

    // CORDIC output x at angle zero, evaluated at elaboration.
    function automatic logic signed [31:0] cordic_gain(input int n);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(CORDIC_ONE);
        y = 0;
        z = 0;
        for (int i = 0; i < n; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0)
            begin
                x = x - dy;
                y = y + dx;
                z = z - longint'(atan_ndeg(5'(i)));
            end
            else
            begin
                x = x + dy;
                y = y - dx;
                z = z + longint'(atan_ndeg(5'(i)));
            end
        end
        return 32'(x);
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/fcpu_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Fly camera pose update: datapath
// Camera state, three shared multiplier lanes, yaw wrap reducer, CORDIC
// rotator, square root and three-lane divider for normalization.
// ----------------------------------------------------------------------------
module fcpu_dp
    import fcpu_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            ctl,
    output dp_sts_t                 sts,
    input  wire logic [3:0]         in_cmd,
    input  wire logic signed [31:0] in_amount,
    input  wire logic [15:0]        in_cursor_x,
    input  wire logic [15:0]        in_cursor_y,
    input  wire logic signed [15:0] in_front_x,
    input  wire logic signed [15:0] in_front_y,
    input  wire logic signed [15:0] in_front_z,
    input  wire logic [15:0]        min_view,
    input  wire logic [15:0]        max_view,
    input  wire logic [11:0]        sens,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [15:0]      dir_x,
    output logic signed [15:0]      dir_y,
    output logic signed [15:0]      dir_z,
    output logic signed [15:0]      view_angle
);

    localparam logic signed [31:0] CORD_G = cordic_gain(TRIG_ITERATIONS);

    // Latched request.
    logic [3:0]         op_reg;
    logic signed [31:0] amt_reg;
    logic [15:0]        cx_reg;
    logic [15:0]        cy_reg;
    logic signed [15:0] nf_reg [3];

    // Camera state.
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] dir_reg [3];
    logic signed [15:0] fov_reg;
    logic [18:0]        yaw_reg;
    logic signed [17:0] pitch_reg;
    logic [15:0]        lcx_reg;
    logic [15:0]        lcy_reg;
    logic               seen_reg;

    // Work registers.
    logic signed [63:0] prod_reg [3];
    logic [CNT_W-1:0]   cnt_reg;
    logic [29:0]        wrap_reg;
    logic signed [31:0] cx_cord_reg;
    logic signed [31:0] cy_cord_reg;
    logic signed [39:0] cz_cord_reg;
    logic               neg_reg;
    logic signed [31:0] cos_yaw_reg;
    logic signed [31:0] sin_yaw_reg;
    logic signed [31:0] cos_pitch_reg;
    logic signed [31:0] sin_pitch_reg;
    logic signed [31:0] v_reg [3];
    logic [63:0]        sqv_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [47:0]        rem_reg [3];
    logic [47:0]        dvs_reg;
    logic [15:0]        q_reg [3];
    logic               ovf_reg [3];
    logic signed [15:0] n_reg [3];

    // Output register.
    logic signed [31:0] opos_reg [3];
    logic signed [15:0] odir_reg [3];
    logic signed [15:0] ofov_reg;

    // Combinational values.
    logic signed [31:0] ma [3];
    logic signed [31:0] mb [3];
    logic signed [63:0] prod_next [3];
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               mv_add;
    logic signed [31:0] pos_mv [3];
    logic signed [23:0] amt_sh;
    logic signed [31:0] updn_next;
    logic signed [25:0] fov_f;
    logic signed [25:0] fov_lo;
    logic signed [25:0] fov_hi;
    logic signed [15:0] fov_chg_next;
    logic signed [15:0] fov_set_next;
    logic signed [31:0] pitch_sum;
    logic signed [17:0] pitch_next;
    logic signed [31:0] wrap_sum;
    logic [29:0]        wrap_cmp;
    logic [29:0]        wrap_next;
    logic signed [19:0] yaw_m;
    logic signed [19:0] ang;
    logic signed [19:0] ang_red;
    logic               ang_neg;
    logic signed [31:0] cdx;
    logic signed [31:0] cdy;
    logic signed [39:0] cat;
    logic signed [31:0] cx_next;
    logic signed [31:0] cy_next;
    logic signed [39:0] cz_next;
    logic signed [31:0] cos_save;
    logic signed [31:0] sin_save;
    logic signed [31:0] v_next [3];
    logic [63:0]        root_bit;
    logic               root_ge;
    logic [31:0]        v_abs [3];
    logic [47:0]        num [3];
    logic [47:0]        len_ext;
    logic signed [15:0] fin [3];
    logic [15:0]        q_clamp [3];

    // Status toward the controller.
    always_comb
    begin
        sts.op        = op_reg;
        sts.wrap_last = (cnt_reg == CNT_W'(WRAP_STEPS - 1));
        sts.cord_last = (cnt_reg == CNT_W'(TRIG_ITERATIONS - 1));
        sts.sqrt_last = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
        sts.div_last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    end

    // Cursor motion, zero on the first cursor request.
    always_comb
    begin
        if (seen_reg)
        begin
            dx = $signed({1'b0, cx_reg}) - $signed({1'b0, lcx_reg});
            dy = $signed({1'b0, lcy_reg}) - $signed({1'b0, cy_reg});
        end
        else
        begin
            dx = '0;
            dy = '0;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma[i] = '0;
            mb[i] = '0;
        end
        case (ctl.mul_sel)
            MUL_DIR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = 32'(dir_reg[i]);
                    mb[i] = amt_reg;
                end
            end
            MUL_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = 32'(n_reg[i]);
                    mb[i] = amt_reg;
                end
            end
            MUL_CUR:
            begin
                ma[0] = 32'(dx);
                ma[1] = 32'(dy);
                mb[0] = $signed({20'd0, sens});
                mb[1] = $signed({20'd0, sens});
            end
            MUL_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = v_reg[i];
                    mb[i] = v_reg[i];
                end
            end
            MUL_FRONT:
            begin
                ma[0] = cos_yaw_reg;
                mb[0] = cos_pitch_reg;
                ma[1] = sin_pitch_reg;
                mb[1] = CORD_G;
                ma[2] = sin_yaw_reg;
                mb[2] = cos_pitch_reg;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 3; i++)
            prod_next[i] = ma[i] * mb[i];
    end

    // Position move along a Q2.14 unit vector, rounded and saturated.
    always_comb
    begin
        logic signed [63:0] pd;
        logic signed [63:0] psum;
        mv_add = (op_reg == CMD_FWD) || (op_reg == CMD_RIGHT);
        for (int i = 0; i < 3; i++)
        begin
            pd   = (prod_reg[i] + 64'(ROUND_Q14)) >>> 14;
            psum = mv_add ? 64'(pos_reg[i]) + pd : 64'(pos_reg[i]) - pd;
            pos_mv[i] = sat32(psum);
        end
    end

    // Up and down moves and field of view updates.
    always_comb
    begin
        logic signed [63:0] ysum;
        amt_sh = 24'(amt_reg >>> 8);
        if (op_reg == CMD_UP)
            ysum = 64'(pos_reg[1]) + 64'(amt_reg);
        else
            ysum = 64'(pos_reg[1]) - 64'(amt_reg);
        updn_next = sat32(ysum);

        fov_lo = (min_view > 16'(FOV_CEIL)) ? 26'(FOV_CEIL) : $signed({10'd0, min_view});
        fov_hi = (max_view > 16'(FOV_CEIL)) ? 26'(FOV_CEIL) : $signed({10'd0, max_view});
        fov_f  = 26'(fov_reg) - 26'(amt_sh);
        if (fov_f < fov_lo)
            fov_f = fov_lo;
        if (fov_f > fov_hi)
            fov_f = fov_hi;
        fov_chg_next = fov_f[15:0];

        if (amt_sh > 24'sd32767)
            fov_set_next = 16'sh7FFF;
        else if (amt_sh < -24'sd32768)
            fov_set_next = 16'sh8000;
        else
            fov_set_next = amt_sh[15:0];
    end

    // Pitch accumulation and biased yaw sum.
    always_comb
    begin
        pitch_sum = 32'(pitch_reg) + prod_reg[1][31:0];
        if (pitch_sum > 32'(PITCH_LIMIT))
            pitch_next = 18'(PITCH_LIMIT);
        else if (pitch_sum < -32'(PITCH_LIMIT))
            pitch_next = -18'(PITCH_LIMIT);
        else
            pitch_next = pitch_sum[17:0];
        wrap_sum  = $signed({13'd0, yaw_reg}) + prod_reg[0][31:0] + 32'(WRAP_BIAS);
        wrap_cmp  = 30'(YAW_FULL) << (CNT_W'(WRAP_STEPS - 1) - cnt_reg);
        wrap_next = (wrap_reg >= wrap_cmp) ? wrap_reg - wrap_cmp : wrap_reg;
    end

    // CORDIC angle reduction into the range of plus or minus 90 degrees.
    always_comb
    begin
        if (yaw_reg > 19'(YAW_HALF))
            yaw_m = $signed({1'b0, yaw_reg}) - 20'(YAW_FULL);
        else
            yaw_m = $signed({1'b0, yaw_reg});
        ang = ctl.cord_sel ? 20'(pitch_reg) : yaw_m;
        ang_neg = 1'b0;
        ang_red = ang;
        if (ang > 20'(ANGLE_QUARTER))
        begin
            ang_red = ang - 20'(YAW_HALF);
            ang_neg = 1'b1;
        end
        else if (ang < -20'(ANGLE_QUARTER))
        begin
            ang_red = ang + 20'(YAW_HALF);
            ang_neg = 1'b1;
        end
    end

    // One CORDIC rotation.
    always_comb
    begin
        cdx = cx_cord_reg >>> cnt_reg;
        cdy = cy_cord_reg >>> cnt_reg;
        cat = atan_ndeg(cnt_reg);
        if (cz_cord_reg >= 0)
        begin
            cx_next = cx_cord_reg - cdy;
            cy_next = cy_cord_reg + cdx;
            cz_next = cz_cord_reg - cat;
        end
        else
        begin
            cx_next = cx_cord_reg + cdy;
            cy_next = cy_cord_reg - cdx;
            cz_next = cz_cord_reg + cat;
        end
        cos_save = neg_reg ? -cx_next : cx_next;
        sin_save = neg_reg ? -cy_next : cy_next;
    end

    // Vector to normalize: right vector or front products.
    always_comb
    begin
        if (ctl.vsrc_front)
        begin
            for (int i = 0; i < 3; i++)
                v_next[i] = 32'(prod_reg[i] >>> 30);
        end
        else
        begin
            v_next[0] = -(32'(dir_reg[2]) <<< 13);
            v_next[1] = '0;
            v_next[2] = 32'(dir_reg[0]) <<< 13;
        end
    end

    // Square root step, divider setup and result rounding.
    always_comb
    begin
        root_bit = root_reg + bit_reg;
        root_ge  = (sqv_reg >= root_bit);
        len_ext  = 48'(root_reg[31:0]);
        for (int i = 0; i < 3; i++)
        begin
            v_abs[i] = (v_reg[i] < 0) ? 32'(-v_reg[i]) : 32'(v_reg[i]);
            num[i]   = (48'(v_abs[i]) << 14) + 48'(root_reg[31:1]);
            if (ovf_reg[i] || (q_reg[i] > 16'(NORM_CEIL)))
                q_clamp[i] = 16'(NORM_CEIL);
            else
                q_clamp[i] = q_reg[i];
            if (root_reg[31:0] == '0)
                fin[i] = '0;
            else if (v_reg[i] < 0)
                fin[i] = -$signed(q_clamp[i]);
            else
                fin[i] = $signed(q_clamp[i]);
        end
    end

    // Camera state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= POS_Z_RESET;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_Z_RESET;
            fov_reg    <= $signed(MIN_VIEW_RESET);
            yaw_reg    <= YAW_RESET;
            pitch_reg  <= '0;
            lcx_reg    <= '0;
            lcy_reg    <= '0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.pos_upd)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ((op_reg == CMD_FWD) || (op_reg == CMD_BACK) || (i != 1))
                        pos_reg[i] <= pos_mv[i];
                end
            end
            if (ctl.simple_upd)
            begin
                case (op_reg)
                    CMD_UP, CMD_DOWN:
                        pos_reg[1] <= updn_next;
                    CMD_FOV_CHG:
                        fov_reg <= fov_chg_next;
                    CMD_FOV_SET:
                        fov_reg <= fov_set_next;
                    CMD_FRONT_SET:
                    begin
                        for (int i = 0; i < 3; i++)
                            dir_reg[i] <= nf_reg[i];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.cur_upd)
            begin
                lcx_reg  <= cx_reg;
                lcy_reg  <= cy_reg;
                seen_reg <= 1'b1;
            end
            if (ctl.cur_add)
                pitch_reg <= pitch_next;
            if (ctl.wrap_step && sts.wrap_last)
                yaw_reg <= wrap_next[18:0];
            if (ctl.dir_from_norm)
            begin
                for (int i = 0; i < 3; i++)
                    dir_reg[i] <= fin[i];
            end
        end
    end

    // Step counter shared by the iterative units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.cur_add || ctl.cord_load || ctl.sqrt_init || ctl.div_init)
            cnt_reg <= '0;
        else if (ctl.wrap_step || ctl.cord_step || ctl.sqrt_step || ctl.div_step)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // Request latch and work registers.
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg    <= in_cmd;
            amt_reg   <= in_amount;
            cx_reg    <= in_cursor_x;
            cy_reg    <= in_cursor_y;
            nf_reg[0] <= in_front_x;
            nf_reg[1] <= in_front_y;
            nf_reg[2] <= in_front_z;
        end
        if (ctl.mul_en)
        begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= prod_next[i];
        end
        if (ctl.cur_add)
            wrap_reg <= wrap_sum[29:0];
        if (ctl.wrap_step)
            wrap_reg <= wrap_next;
        if (ctl.cord_load)
        begin
            cx_cord_reg <= 32'(CORDIC_ONE);
            cy_cord_reg <= '0;
            cz_cord_reg <= 40'(ang_red) * 40'(NDEG_PER_MDEG);
            neg_reg     <= ang_neg;
        end
        if (ctl.cord_step)
        begin
            cx_cord_reg <= cx_next;
            cy_cord_reg <= cy_next;
            cz_cord_reg <= cz_next;
            if (sts.cord_last)
            begin
                if (ctl.cord_sel)
                begin
                    cos_pitch_reg <= cos_save;
                    sin_pitch_reg <= sin_save;
                end
                else
                begin
                    cos_yaw_reg <= cos_save;
                    sin_yaw_reg <= sin_save;
                end
            end
        end
        if (ctl.vload)
        begin
            for (int i = 0; i < 3; i++)
                v_reg[i] <= v_next[i];
        end
        if (ctl.sqrt_init)
        begin
            sqv_reg  <= 64'(prod_reg[0]) + 64'(prod_reg[1]) + 64'(prod_reg[2]);
            root_reg <= '0;
            bit_reg  <= 64'd1 << 62;
        end
        if (ctl.sqrt_step)
        begin
            if (root_ge)
            begin
                sqv_reg  <= sqv_reg - root_bit;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (ctl.div_init)
        begin
            dvs_reg <= len_ext << 15;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= num[i];
                q_reg[i]   <= '0;
                ovf_reg[i] <= (num[i] >= (len_ext << 16));
            end
        end
        if (ctl.div_step)
        begin
            dvs_reg <= dvs_reg >> 1;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= dvs_reg)
                begin
                    rem_reg[i] <= rem_reg[i] - dvs_reg;
                    q_reg[i]   <= {q_reg[i][14:0], 1'b1};
                end
                else
                    q_reg[i] <= {q_reg[i][14:0], 1'b0};
            end
        end
        if (ctl.norm_store)
        begin
            for (int i = 0; i < 3; i++)
                n_reg[i] <= fin[i];
        end
        if (ctl.out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                opos_reg[i] <= pos_reg[i];
                odir_reg[i] <= dir_reg[i];
            end
            ofov_reg <= fov_reg;
        end
    end

    assign pos_x      = opos_reg[0];
    assign pos_y      = opos_reg[1];
    assign pos_z      = opos_reg[2];
    assign dir_x      = odir_reg[0];
    assign dir_y      = odir_reg[1];
    assign dir_z      = odir_reg[2];
    assign view_angle = ofov_reg;

endmodule
`default_nettype wire

// ----- sv/fcpu_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Fly camera pose update: controller
// One-hot state machine that sequences the datapath for each request and
// owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module fcpu_ctrl
    import fcpu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      ctl
);

    typedef enum logic [20:0] {
        S_IDLE       = 21'h000001,
        S_DECODE     = 21'h000002,
        S_MOVE_MUL   = 21'h000004,
        S_MOVE_ADD   = 21'h000008,
        S_SIMPLE     = 21'h000010,
        S_CUR_MUL    = 21'h000020,
        S_CUR_ADD    = 21'h000040,
        S_WRAP       = 21'h000080,
        S_YAW_LOAD   = 21'h000100,
        S_YAW_RUN    = 21'h000200,
        S_PITCH_LOAD = 21'h000400,
        S_PITCH_RUN  = 21'h000800,
        S_FRONT_MUL  = 21'h001000,
        S_FRONT_V    = 21'h002000,
        S_SQ_MUL     = 21'h004000,
        S_SQRT_INIT  = 21'h008000,
        S_SQRT_RUN   = 21'h010000,
        S_DIV_INIT   = 21'h020000,
        S_DIV_RUN    = 21'h040000,
        S_NORM_DONE  = 21'h080000,
        S_OUT        = 21'h100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.mul_sel = MUL_DIR;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    CMD_FWD, CMD_BACK:
                        state_next = S_MOVE_MUL;
                    CMD_LEFT, CMD_RIGHT:
                    begin
                        ctl.vload  = 1'b1;
                        state_next = S_SQ_MUL;
                    end
                    CMD_CURSOR:
                        state_next = S_CUR_MUL;
                    default:
                        state_next = S_SIMPLE;
                endcase
            end
            S_MOVE_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = (sts.op inside {CMD_LEFT, CMD_RIGHT}) ? MUL_NORM : MUL_DIR;
                state_next  = S_MOVE_ADD;
            end
            S_MOVE_ADD:
            begin
                ctl.pos_upd = 1'b1;
                state_next  = S_OUT;
            end
            S_SIMPLE:
            begin
                ctl.simple_upd = 1'b1;
                state_next     = S_OUT;
            end
            S_CUR_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_CUR;
                ctl.cur_upd = 1'b1;
                state_next  = S_CUR_ADD;
            end
            S_CUR_ADD:
            begin
                ctl.cur_add = 1'b1;
                state_next  = S_WRAP;
            end
            S_WRAP:
            begin
                ctl.wrap_step = 1'b1;
                if (sts.wrap_last)
                    state_next = S_YAW_LOAD;
            end
            S_YAW_LOAD:
            begin
                ctl.cord_load = 1'b1;
                state_next    = S_YAW_RUN;
            end
            S_YAW_RUN:
            begin
                ctl.cord_step = 1'b1;
                if (sts.cord_last)
                    state_next = S_PITCH_LOAD;
            end
            S_PITCH_LOAD:
            begin
                ctl.cord_load = 1'b1;
                ctl.cord_sel  = 1'b1;
                state_next    = S_PITCH_RUN;
            end
            S_PITCH_RUN:
            begin
                ctl.cord_step = 1'b1;
                ctl.cord_sel  = 1'b1;
                if (sts.cord_last)
                    state_next = S_FRONT_MUL;
            end
            S_FRONT_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_FRONT;
                state_next  = S_FRONT_V;
            end
            S_FRONT_V:
            begin
                ctl.vload      = 1'b1;
                ctl.vsrc_front = 1'b1;
                state_next     = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_SQ;
                state_next  = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                ctl.sqrt_init = 1'b1;
                state_next    = S_SQRT_RUN;
            end
            S_SQRT_RUN:
            begin
                ctl.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                ctl.div_init = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_NORM_DONE;
            end
            S_NORM_DONE:
            begin
                if (sts.op == CMD_CURSOR)
                begin
                    ctl.dir_from_norm = 1'b1;
                    state_next        = S_OUT;
                end
                else
                begin
                    ctl.norm_store = 1'b1;
                    state_next     = S_MOVE_MUL;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid holds until the result is taken.
    always_comb
    begin
        if (ctl.out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule
`default_nettype wire

// ----- sv/fly_camera_pose_update.sv -----
`default_nettype none
// Read, fov, up/down and front set requests pass through the simple update state; forward and
// back moves add a multiply, and left and right moves first normalize the right vector
// (32-step square root, 16-step divider). Cursor requests run the yaw wrap, the two CORDIC
// rotations, the square root and the divider; one request is in work at a time, the next is accepted
// while the previous result waits in the output register.
// Reset restores the pose, field of view, angles and the configuration register defaults.
// ----------------------------------------------------------------------------
// Fly camera pose update: top level
// Stream ports for requests and results, APB configuration registers, and
// the controller and datapath.
// ----------------------------------------------------------------------------
module fly_camera_pose_update
    import fcpu_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd[3:0], amount[35:4], cursor_x[51:36], cursor_y[67:52],
    // new_front_x[83:68], new_front_y[99:84], new_front_z[115:100], zero pad
    input  wire logic [119:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], dir_x[111:96], dir_y[127:112],
    // dir_z[143:128], view_angle[159:144]
    output logic [159:0]      m_tdata
);

    logic [15:0] min_view_reg;
    logic [15:0] max_view_reg;
    logic [11:0] sens_reg;
    logic        cfg_wr;
    dp_cmd_t     ctl;
    dp_sts_t     sts;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] view_angle;

    // Configuration register writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_view_reg <= MIN_VIEW_RESET;
            max_view_reg <= MAX_VIEW_RESET;
            sens_reg     <= SENS_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MIN_VIEW: min_view_reg <= pwdata[15:0];
                REG_MAX_VIEW: max_view_reg <= pwdata[15:0];
                REG_SENS:     sens_reg     <= pwdata[11:0];
                default:
                begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_VIEW: prdata = {16'd0, min_view_reg};
            REG_MAX_VIEW: prdata = {16'd0, max_view_reg};
            REG_SENS:     prdata = {20'd0, sens_reg};
            default:      prdata = '0;
        endcase
    end

    fcpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    fcpu_dp #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_cmd      (s_tdata[3:0]),
        .in_amount   ($signed(s_tdata[35:4])),
        .in_cursor_x (s_tdata[51:36]),
        .in_cursor_y (s_tdata[67:52]),
        .in_front_x  ($signed(s_tdata[83:68])),
        .in_front_y  ($signed(s_tdata[99:84])),
        .in_front_z  ($signed(s_tdata[115:100])),
        .min_view    (min_view_reg),
        .max_view    (max_view_reg),
        .sens        (sens_reg),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .view_angle  (view_angle)
    );

    assign m_tdata = {view_angle, dir_z, dir_y, dir_x, pos_z, pos_y, pos_x};

    // The block is busy in the cycle after it takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is still in work");

    // A new result appears only while no request can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result presented from the idle state");

    // A result is loaded only when the output slot is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- bench/fly_camera_pose_update_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fly camera pose update: testbench
// Drives camera commands and register writes, predicts each pose result with
// an internal model of the camera and compares every result field by field.
// ----------------------------------------------------------------------------
module fly_camera_pose_update_test;
    import fcpu_pkg::*;

    // One predicted or observed pose, laid out as on the result bus.
    typedef struct packed {
        logic signed [15:0] fov;
        logic signed [15:0] dz;
        logic signed [15:0] dy;
        logic signed [15:0] dx;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } pose_t;

    // Camera model and queue of expected poses.
    class pose_board;
        longint pos[3];
        longint dir[3];
        longint fov;
        longint yaw;
        longint pitch;
        longint last_x;
        longint last_y;
        bit seen;
        longint min_fov;
        longint max_fov;
        longint sens;
        pose_t pending[$];
        int errors;

        function void reset_pose();
            pos[0] = 0;
            pos[1] = 0;
            pos[2] = 64'd262144;
            dir[0] = 0;
            dir[1] = 0;
            dir[2] = -16384;
            fov = 256;
            yaw = 270000;
            pitch = 0;
            last_x = 0;
            last_y = 0;
            seen = 0;
            min_fov = 256;
            max_fov = 11520;
            sens = 100;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == REG_MIN_VIEW)
                min_fov = v[15:0];
            else if (idx == REG_MAX_VIEW)
                max_fov = v[15:0];
            else if (idx == REG_SENS)
                sens = v[11:0];
        endfunction

        // Arithmetic shift right that floors.
        function longint fl(longint v, int n);
            return v >>> n;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint root(longint v);
            longint r;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v)
                    r = r + (64'd1 << b);
            end
            return r;
        endfunction

        function void unit3(longint v[3], output longint o[3]);
            longint s;
            longint len;
            longint a;
            longint q;
            s = 0;
            for (int i = 0; i < 3; i++)
                s += (v[i] < 0 ? -v[i] : v[i]) * (v[i] < 0 ? -v[i] : v[i]);
            len = root(s);
            for (int i = 0; i < 3; i++)
            begin
                if (len == 0)
                    o[i] = 0;
                else
                begin
                    a = (v[i] < 0 ? -v[i] : v[i]) * 16384;
                    q = (a + len / 2) / len;
                    if (q > 32767)
                        q = 32767;
                    o[i] = v[i] < 0 ? -q : q;
                end
            end
        endfunction

        function void rotate(longint ang, output longint c, output longint s);
            longint x;
            longint y;
            longint z;
            longint tx;
            x = 64'd1 << 28;
            y = 0;
            z = ang;
            for (int i = 0; i < 16; i++)
            begin
                tx = x;
                if (z >= 0)
                begin
                    x = x - fl(y, i);
                    y = y + fl(tx, i);
                    z = z - atan_ndeg(5'(i));
                end
                else
                begin
                    x = x + fl(y, i);
                    y = y - fl(tx, i);
                    z = z + atan_ndeg(5'(i));
                end
            end
            c = x;
            s = y;
        endfunction

        function void sincos(longint m, output longint c, output longint s);
            bit flip;
            flip = 0;
            if (m > 90000)
            begin
                m -= 180000;
                flip = 1;
            end
            else if (m < -90000)
            begin
                m += 180000;
                flip = 1;
            end
            rotate(m * 1000000, c, s);
            if (flip)
            begin
                c = -c;
                s = -s;
            end
        endfunction

        function void shift_axis(int ax, longint u, longint amt, bit add);
            longint d;
            d = fl(u * amt + 8192, 14);
            pos[ax] = clip(add ? pos[ax] + d : pos[ax] - d, -64'sd2147483648, 64'sd2147483647);
        endfunction

        // Applies one accepted command and queues the pose it produces.
        function void note_request(logic [119:0] d);
            logic [3:0] op;
            longint amt;
            longint cx;
            longint cy;
            longint v[3];
            longint r[3];
            longint lo;
            longint hi;
            longint f;
            longint ycos;
            longint ysin;
            longint pcos;
            longint psin;
            longint g;
            longint dummy;
            longint ym;
            longint ddx;
            longint ddy;
            pose_t p;
            op = d[3:0];
            amt = longint'($signed(d[35:4]));
            cx = d[51:36];
            cy = d[67:52];
            case (op)
                CMD_FWD, CMD_BACK:
                    for (int i = 0; i < 3; i++)
                        shift_axis(i, dir[i], amt, op == CMD_FWD);
                CMD_LEFT, CMD_RIGHT:
                begin
                    v[0] = -dir[2] * 8192;
                    v[1] = 0;
                    v[2] = dir[0] * 8192;
                    unit3(v, r);
                    shift_axis(0, r[0], amt, op == CMD_RIGHT);
                    shift_axis(2, r[2], amt, op == CMD_RIGHT);
                end
                CMD_UP:
                    pos[1] = clip(pos[1] + amt, -64'sd2147483648, 64'sd2147483647);
                CMD_DOWN:
                    pos[1] = clip(pos[1] - amt, -64'sd2147483648, 64'sd2147483647);
                CMD_FOV_CHG:
                begin
                    lo = min_fov > 32767 ? 32767 : min_fov;
                    hi = max_fov > 32767 ? 32767 : max_fov;
                    f = fov - fl(amt, 8);
                    if (f < lo)
                        f = lo;
                    if (f > hi)
                        f = hi;
                    fov = f;
                end
                CMD_FOV_SET:
                    fov = clip(fl(amt, 8), -32768, 32767);
                CMD_CURSOR:
                begin
                    if (!seen)
                    begin
                        last_x = cx;
                        last_y = cy;
                        seen = 1;
                    end
                    ddx = cx - last_x;
                    ddy = last_y - cy;
                    last_x = cx;
                    last_y = cy;
                    yaw = (yaw + ddx * sens) % 360000;
                    if (yaw < 0)
                        yaw += 360000;
                    pitch = clip(pitch + ddy * sens, -89000, 89000);
                    ym = yaw > 180000 ? yaw - 360000 : yaw;
                    sincos(ym, ycos, ysin);
                    sincos(pitch, pcos, psin);
                    rotate(0, g, dummy);
                    v[0] = fl(ycos * pcos, 30);
                    v[1] = fl(psin * g, 30);
                    v[2] = fl(ysin * pcos, 30);
                    unit3(v, dir);
                end
                CMD_FRONT_SET:
                begin
                    dir[0] = longint'($signed(d[83:68]));
                    dir[1] = longint'($signed(d[99:84]));
                    dir[2] = longint'($signed(d[115:100]));
                end
                default:
                    ;
            endcase
            p.px = pos[0][31:0];
            p.py = pos[1][31:0];
            p.pz = pos[2][31:0];
            p.dx = dir[0][15:0];
            p.dy = dir[1][15:0];
            p.dz = dir[2][15:0];
            p.fov = fov[15:0];
            pending.push_back(p);
        endfunction

        // Compares one observed pose with the oldest expectation.
        function void check_result(pose_t got);
            pose_t exp_p;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_p = pending.pop_front();
            if (got !== exp_p)
            begin
                errors++;
                if (errors <= 10)
                    $display("pose mismatch: exp pos %0d %0d %0d dir %0d %0d %0d fov %0d, got pos %0d %0d %0d dir %0d %0d %0d fov %0d",
                        exp_p.px, exp_p.py, exp_p.pz, exp_p.dx, exp_p.dy, exp_p.dz, exp_p.fov,
                        got.px, got.py, got.pz, got.dx, got.dy, got.dz, got.fov);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid;
    logic s_tready;
    logic [119:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [159:0] m_tdata;

    pose_board board;
    int send_idle;
    int recv_idle;
    int quiet_cycles;
    int cursor_x_now;
    int cursor_y_now;

    fly_camera_pose_update uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Result side: random stall, check on every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sends one request and waits for it to be accepted; valid stays up
    // until the next idle cycle or drain, so requests can follow back to back.
    task automatic send_request(cmd_code_t op, logic [31:0] amt, logic [15:0] cx,
                                logic [15:0] cy, logic [15:0] fx, logic [15:0] fy,
                                logic [15:0] fz);
        logic [119:0] d;
        d = {4'd0, fz, fy, fx, cy, cx, amt, 4'(op)};
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(d);
    endtask

    task automatic send_raw(logic [3:0] op, logic [31:0] amt);
        send_request(cmd_code_t'(op), amt, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
    endtask

    // Waits for every expected result, then for the block to go quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(idx, v);
    endtask

    task automatic set_regs(logic [15:0] lo, logic [15:0] hi, logic [11:0] s);
        drain();
        write_reg(REG_MIN_VIEW, {16'd0, lo});
        write_reg(REG_MAX_VIEW, {16'd0, hi});
        write_reg(REG_SENS, {20'd0, s});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One random command, mostly moves and cursor motion of modest size.
    task automatic random_request();
        int pick;
        logic [31:0] amt;
        pick = $urandom_range(99);
        amt = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        if (pick < 30)
        begin
            if ($urandom_range(9) == 0)
            begin
                cursor_x_now = $urandom_range(65535);
                cursor_y_now = $urandom_range(65535);
            end
            else
            begin
                cursor_x_now = (cursor_x_now + $urandom_range(400) - 200) & 16'hFFFF;
                cursor_y_now = (cursor_y_now + $urandom_range(400) - 200) & 16'hFFFF;
            end
            send_request(CMD_CURSOR, amt, 16'(cursor_x_now), 16'(cursor_y_now),
                         16'($urandom), 16'($urandom), 16'($urandom));
        end
        else if (pick < 35)
            send_raw(4'($urandom_range(15, 11)), amt);
        else
            send_raw(4'($urandom_range(10)), amt);
    endtask

    task automatic random_phase(int n);
        repeat (n)
            random_request();
    endtask

    initial
    begin
        board = new();
        board.reset_pose();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        quiet_cycles = 0;
        cursor_x_now = 1000;
        cursor_y_now = 1000;
        send_idle = 25;
        recv_idle = 83;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each command, field extremes, first cursor, pitch limit, yaw wrap.
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0);
        send_request(CMD_LEFT, 32'h0001_0000, 0, 0, 0, 0, 0);
        send_request(CMD_FWD, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_request(CMD_FWD, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_request(CMD_BACK, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_request(CMD_UP, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_request(CMD_UP, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_request(CMD_DOWN, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_request(CMD_FOV_CHG, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_request(CMD_FOV_CHG, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_request(CMD_FOV_SET, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_request(CMD_FOV_SET, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        send_request(CMD_CURSOR, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        send_request(CMD_CURSOR, 0, 16'h0000, 16'h0000, 0, 0, 0);
        send_request(CMD_CURSOR, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        send_request(CMD_CURSOR, 0, 16'h8000, 16'h8000, 0, 0, 0);
        send_request(CMD_FRONT_SET, 0, 0, 0, 16'h0000, 16'h4000, 16'h0000);
        send_request(CMD_RIGHT, 32'h0001_0000, 0, 0, 0, 0, 0);
        send_request(CMD_FRONT_SET, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000);
        send_request(CMD_RIGHT, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_request(CMD_BACK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        send_request(cmd_code_t'(4'hF), 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Crossed bounds and bounds above the signed range, large sensitivity.
        set_regs(16'hFFFF, 16'h0000, 12'hFFF);
        send_request(CMD_FOV_CHG, 32'h0000_1000, 0, 0, 0, 0, 0);
        random_phase(150);
        set_regs(16'h0000, 16'hB400, 12'h000);
        random_phase(150);
        set_regs(16'hB400, 16'hFFFF, 12'd1);
        random_phase(150);
        set_regs(16'd256, 16'd11520, 12'd100);
        random_phase(350);

        send_idle = 83;
        recv_idle = 25;
        random_phase(450);
        send_idle = 0;
        recv_idle = 0;
        set_regs(16'd1000, 16'd20000, 12'd500);
        random_phase(450);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
